>>> rtl/ndrd_pkg.sv
// ----------------------------------------------------------------------------
// ndrd_pkg
// Shared types and codes for the NTFS data run decoder.
// ----------------------------------------------------------------------------
package ndrd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_LENGTH = 2'd2,
    PH_OFFSET = 2'd3
  } ndrd_phase_t;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_END = 2'd1,
    ST_BAD = 2'd2
  } ndrd_status_t;

  typedef struct packed {
    logic [31:0] run_length;
    logic [31:0] run_cluster;
    logic        sparse_run;
    logic [1:0]  status;
  } ndrd_result_t;

  localparam logic [7:0] END_HEADER = 8'h00;
  localparam logic [31:0] SPARSE_CLUSTER = 32'hFFFF_FFFF;

endpackage

>>> rtl/ndrd_if.sv
// ----------------------------------------------------------------------------
// ndrd channel interfaces
// Valid/ready channels for runlist bytes in and decoded runs out.
// ----------------------------------------------------------------------------
interface ndrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       list_start;

  modport source (output valid, output data_byte, output list_start, input ready);
  modport sink   (input valid, input data_byte, input list_start, output ready);
endinterface

interface ndrd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] run_length;
  logic [31:0] run_cluster;
  logic        sparse_run;
  logic [1:0]  status;

  modport source (output valid, output run_length, output run_cluster,
                  output sparse_run, output status, input ready);
  modport sink   (input valid, input run_length, input run_cluster,
                  input sparse_run, input status, output ready);
endinterface

>>> rtl/ntfs_data_run_decoder.sv
// ----------------------------------------------------------------------------
// ntfs_data_run_decoder
// Byte-serial NTFS runlist (mapping pairs) decoder.
// ----------------------------------------------------------------------------
// Takes one runlist byte per cycle. A byte with list_start set is the first
// header of a list and clears the running cluster sum. Each completed run
// yields its length, its starting cluster (the wrapping 32-bit sum of the
// sign-extended offsets) and a sparse flag; a 0x00 header gives an end
// status and an illegal header an error status, both leaving the decoder
// idle until the next list_start. A result is written into a two-entry
// output buffer as the last byte of its run is accepted, together with the
// decoder state update, so input is taken every cycle unless both
// buffer entries are waiting for the downstream side.
module ntfs_data_run_decoder
  import ndrd_pkg::*;
#(
  parameter int MAX_FIELD_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  ndrd_in_if.sink    in_ch,
  ndrd_out_if.source out_ch
);

  localparam int CW = $clog2(MAX_FIELD_BYTES + 1);

  ndrd_phase_t  phase_r, phase_nxt, phase_eff;
  logic [CW-1:0] len_bytes_r, off_bytes_r, idx_r;
  logic [CW-1:0] len_bytes_nxt, off_bytes_nxt, idx_nxt, idx_inc;
  logic [31:0]  len_acc_r, off_acc_r, sum_r;
  logic [31:0]  len_acc_nxt, off_acc_nxt, sum_nxt, sum_base;
  logic [31:0]  len_merge, off_merge, off_ext, byte_shifted;
  logic [3:0]   lnib, onib;
  logic         accept, push_ready, res_valid;
  logic         hdr_end, hdr_bad, len_last, off_last;
  ndrd_result_t res;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  assign phase_eff = in_ch.list_start ? PH_HEADER : phase_r;
  assign sum_base  = in_ch.list_start ? 32'd0 : sum_r;

  assign lnib    = in_ch.data_byte[3:0];
  assign onib    = in_ch.data_byte[7:4];
  assign hdr_end = (in_ch.data_byte == END_HEADER);
  assign hdr_bad = (lnib == 4'd0) || (32'(lnib) > 32'(MAX_FIELD_BYTES))
                || (32'(onib) > 32'(MAX_FIELD_BYTES));

  // bytes past the fourth shift out of range and drop
  assign byte_shifted = 32'(in_ch.data_byte) << (32'(idx_r) * 32'd8);
  assign len_merge    = len_acc_r | byte_shifted;
  assign off_merge    = off_acc_r | byte_shifted;
  assign idx_inc      = idx_r + CW'(1);
  assign len_last     = !(idx_inc < len_bytes_r);
  assign off_last     = !(idx_inc < off_bytes_r);

  always_comb begin
    unique case (32'(off_bytes_r))
      32'd1:   off_ext = {{24{off_merge[7]}},  off_merge[7:0]};
      32'd2:   off_ext = {{16{off_merge[15]}}, off_merge[15:0]};
      32'd3:   off_ext = {{8{off_merge[23]}},  off_merge[23:0]};
      default: off_ext = off_merge;
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = phase_eff;
    unique case (phase_eff)
      PH_HEADER: phase_nxt = (hdr_end || hdr_bad) ? PH_IDLE : PH_LENGTH;
      PH_LENGTH: begin
        if (len_last) phase_nxt = (off_bytes_r == '0) ? PH_HEADER : PH_OFFSET;
      end
      PH_OFFSET: begin
        if (off_last) phase_nxt = PH_HEADER;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    len_bytes_nxt = len_bytes_r;
    off_bytes_nxt = off_bytes_r;
    idx_nxt       = idx_r;
    len_acc_nxt   = len_acc_r;
    off_acc_nxt   = off_acc_r;
    sum_nxt       = sum_base;
    res_valid     = 1'b0;
    res           = '{run_length: 32'd0, run_cluster: 32'd0, sparse_run: 1'b0,
                      status: ST_RUN};
    unique case (phase_eff)
      PH_HEADER: begin
        if (hdr_end) begin
          res_valid  = 1'b1;
          res.status = ST_END;
        end else if (hdr_bad) begin
          res_valid  = 1'b1;
          res.status = ST_BAD;
        end else begin
          len_bytes_nxt = CW'(lnib);
          off_bytes_nxt = CW'(onib);
          idx_nxt       = '0;
          len_acc_nxt   = 32'd0;
          off_acc_nxt   = 32'd0;
        end
      end
      PH_LENGTH: begin
        len_acc_nxt = len_merge;
        idx_nxt     = len_last ? '0 : idx_inc;
        if (len_last) begin
          off_acc_nxt = 32'd0;
          if (off_bytes_r == '0) begin
            res_valid       = 1'b1;
            res.run_length  = len_merge;
            res.run_cluster = SPARSE_CLUSTER;
            res.sparse_run  = 1'b1;
          end
        end
      end
      PH_OFFSET: begin
        off_acc_nxt = off_merge;
        idx_nxt     = off_last ? '0 : idx_inc;
        if (off_last) begin
          off_acc_nxt     = off_ext;
          sum_nxt         = sum_base + off_ext;
          res_valid       = 1'b1;
          res.run_length  = len_acc_r;
          res.run_cluster = sum_base + off_ext;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      len_bytes_r <= '0;
      off_bytes_r <= '0;
      idx_r       <= '0;
      len_acc_r   <= 32'd0;
      off_acc_r   <= 32'd0;
      sum_r       <= 32'd0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      len_bytes_r <= len_bytes_nxt;
      off_bytes_r <= off_bytes_nxt;
      idx_r       <= idx_nxt;
      len_acc_r   <= len_acc_nxt;
      off_acc_r   <= off_acc_nxt;
      sum_r       <= sum_nxt;
    end
  end

  ndrd_out_skid u_out_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (accept && res_valid),
    .push_data  (res),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

endmodule

>>> rtl/ndrd_out_skid.sv
// ----------------------------------------------------------------------------
// ndrd_out_skid
// Two-entry result buffer; keeps the decoder running while a result waits.
// ----------------------------------------------------------------------------
module ndrd_out_skid
  import ndrd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  ndrd_result_t  push_data,
  output logic          push_ready,
  ndrd_out_if.source    out_ch
);

  ndrd_result_t e0_r, e1_r;
  logic [1:0]   cnt_r;
  logic         push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign push       = push_valid && push_ready;
  assign pop        = (cnt_r != 2'd0) && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10: begin
          if (cnt_r == 2'd0) e0_r <= push_data;
          else               e1_r <= push_data;
          cnt_r <= cnt_r + 2'd1;
        end
        2'b01: begin
          e0_r  <= e1_r;
          cnt_r <= cnt_r - 2'd1;
        end
        2'b11: begin
          if (cnt_r == 2'd1) begin
            e0_r <= push_data;
          end else begin
            e0_r <= e1_r;
            e1_r <= push_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.run_length  = e0_r.run_length;
  assign out_ch.run_cluster = e0_r.run_cluster;
  assign out_ch.sparse_run  = e0_r.sparse_run;
  assign out_ch.status      = e0_r.status;

endmodule

>>> verif/ndrd_run_checker.sv
// ----------------------------------------------------------------------------
// ndrd_run_checker
// Watches both channels of the runlist decoder. It decodes every accepted
// byte on its own and compares each result transfer, field by field, with
// the oldest decoded run still waiting.
// ----------------------------------------------------------------------------
module ndrd_run_checker
  import ndrd_pkg::*;
#(
  parameter int MAX_FIELD_BYTES = 4
) (
  input  logic clk,
  input  logic rst_n,
  ndrd_in_if   in_ch,
  ndrd_out_if  out_ch,
  output int   mismatches,
  output int   outstanding,
  output int   runs_seen,
  output int   sparse_seen,
  output int   ends_seen,
  output int   bad_seen
);

  ndrd_phase_t  dec_phase;
  int           len_bytes;
  int           off_bytes;
  int           field_idx;
  logic [31:0]  len_acc;
  logic [31:0]  off_acc;
  logic [31:0]  cluster_sum;
  ndrd_result_t pending_runs[$];
  int           err_count;
  int           n_runs, n_sparse, n_ends, n_bad;

  task automatic queue_result(input logic [31:0] len, input logic [31:0] clu,
                              input logic sp, input ndrd_status_t st);
    ndrd_result_t r;
    r.run_length  = len;
    r.run_cluster = clu;
    r.sparse_run  = sp;
    r.status      = st;
    pending_runs.push_back(r);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic s);
    int lnib;
    int onib;
    int bits;
    lnib = int'(b[3:0]);
    onib = int'(b[7:4]);
    // a list start drops any partial run and clears the sum
    if (s) begin
      cluster_sum = '0;
      dec_phase   = PH_HEADER;
    end
    case (dec_phase)
      PH_HEADER: begin
        if (b == END_HEADER) begin
          dec_phase = PH_IDLE;
          queue_result('0, '0, 1'b0, ST_END);
        end else if (lnib < 1 || lnib > MAX_FIELD_BYTES || onib > MAX_FIELD_BYTES) begin
          dec_phase = PH_IDLE;
          queue_result('0, '0, 1'b0, ST_BAD);
        end else begin
          len_bytes = lnib;
          off_bytes = onib;
          field_idx = 0;
          len_acc   = '0;
          off_acc   = '0;
          dec_phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (field_idx < 4) len_acc |= 32'(b) << (8 * field_idx);
        field_idx++;
        if (field_idx >= len_bytes) begin
          field_idx = 0;
          if (off_bytes == 0) begin
            dec_phase = PH_HEADER;
            queue_result(len_acc, SPARSE_CLUSTER, 1'b1, ST_RUN);
          end else begin
            off_acc   = '0;
            dec_phase = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        if (field_idx < 4) off_acc |= 32'(b) << (8 * field_idx);
        field_idx++;
        if (field_idx >= off_bytes) begin
          field_idx = 0;
          // sign-extend short offsets before adding
          if (off_bytes < 4) begin
            bits = 8 * off_bytes;
            if (off_acc[bits-1]) off_acc |= 32'hFFFF_FFFF << bits;
          end
          cluster_sum = cluster_sum + off_acc;
          dec_phase   = PH_HEADER;
          queue_result(len_acc, cluster_sum, 1'b0, ST_RUN);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    ndrd_result_t e;
    if (pending_runs.size() == 0) begin
      $error("unexpected result: status %0d length %h cluster %h",
             out_ch.status, out_ch.run_length, out_ch.run_cluster);
      err_count++;
    end else begin
      e = pending_runs.pop_front();
      if (out_ch.run_length !== e.run_length) begin
        $error("run_length: expected %h, got %h", e.run_length, out_ch.run_length);
        err_count++;
      end
      if (out_ch.run_cluster !== e.run_cluster) begin
        $error("run_cluster: expected %h, got %h", e.run_cluster, out_ch.run_cluster);
        err_count++;
      end
      if (out_ch.sparse_run !== e.sparse_run) begin
        $error("sparse_run: expected %0d, got %0d", e.sparse_run, out_ch.sparse_run);
        err_count++;
      end
      if (out_ch.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, out_ch.status);
        err_count++;
      end
      case (e.status)
        ST_RUN: begin
          n_runs++;
          if (e.sparse_run) n_sparse++;
        end
        ST_END: n_ends++;
        default: n_bad++;
      endcase
    end
  endtask

  initial begin
    err_count = 0;
    n_runs    = 0;
    n_sparse  = 0;
    n_ends    = 0;
    n_bad     = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      dec_phase   = PH_IDLE;
      len_bytes   = 0;
      off_bytes   = 0;
      field_idx   = 0;
      len_acc     = '0;
      off_acc     = '0;
      cluster_sum = '0;
      pending_runs.delete();
    end else begin
      // a result leaves the output buffer only after its last byte is taken: check first
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte, in_ch.list_start);
    end
    mismatches  <= err_count;
    outstanding <= pending_runs.size();
    runs_seen   <= n_runs;
    sparse_seen <= n_sparse;
    ends_seen   <= n_ends;
    bad_seen    <= n_bad;
  end

endmodule

>>> verif/ntfs_data_run_decoder_test.sv
// ----------------------------------------------------------------------------
// ntfs_data_run_decoder_test
// Feeds runlist byte streams into the decoder: a directed opening on header
// and field corner cases, then random lists of runs with random field bytes,
// broken lists and ignored bytes, under random gaps on input and output.
// ----------------------------------------------------------------------------
module ntfs_data_run_decoder_test;
  import ndrd_pkg::*;

  localparam int MAX_FIELD_BYTES = 4;
  localparam int NUM_ITEMS       = 1400;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches, outstanding;
  int   runs_seen, sparse_seen, ends_seen, bad_seen;
  int   items_sent = 0;
  int   lists_sent = 0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;
  int   out_calm_left = 0;
  int   stall_left = 0;

  ndrd_in_if  in_ch();
  ndrd_out_if out_ch();

  ntfs_data_run_decoder #(.MAX_FIELD_BYTES(MAX_FIELD_BYTES)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ndrd_run_checker #(.MAX_FIELD_BYTES(MAX_FIELD_BYTES)) i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .runs_seen   (runs_seen),
    .sparse_seen (sparse_seen),
    .ends_seen   (ends_seen),
    .bad_seen    (bad_seen)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // field bytes lean toward the extremes
  function automatic logic [7:0] field_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] bad_header();
    logic [7:0] b;
    do begin
      b = 8'($urandom);
    end while (b == END_HEADER ||
               (b[3:0] >= 1 && b[3:0] <= MAX_FIELD_BYTES && b[7:4] <= MAX_FIELD_BYTES));
    return b;
  endfunction

  // Drive one byte from a falling edge and hold it until the transfer.
  task automatic push_byte(input logic [7:0] b, input logic s, input bit counted);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.list_start <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (counted) items_sent++;
  endtask

  // One run: header then its fields; a cut run stops short of its last byte.
  task automatic send_run(input bit first, input bit cut);
    int len_n;
    int off_n;
    int n;
    len_n = $urandom_range(1, MAX_FIELD_BYTES);
    off_n = $urandom_range(0, MAX_FIELD_BYTES);
    push_byte({4'(off_n), 4'(len_n)}, first, 1'b1);
    n = cut ? $urandom_range(0, len_n + off_n - 1) : len_n + off_n;
    for (int i = 0; i < n; i++) push_byte(field_byte(), 1'b0, 1'b1);
  endtask

  task automatic send_list();
    int  runs;
    int  r;
    bit  idle_after;
    if ($urandom_range(0, 9) == 0) in_calm = !in_calm;
    runs = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
    for (int i = 0; i < runs; i++) send_run(i == 0, 1'b0);
    r = $urandom_range(0, 99);
    idle_after = 1'b1;
    if (r < 75) begin
      push_byte(END_HEADER, runs == 0, 1'b1);
    end else if (r < 88) begin
      push_byte(bad_header(), runs == 0, 1'b1);
    end else begin
      send_run(runs == 0, 1'b1);
      idle_after = 1'b0;
    end
    // bytes without a list start while idle are dropped by the decoder
    if (idle_after && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0, 1'b0);
    end
    lists_sent++;
  endtask

  // Output side: random stalls with calm stretches of constant ready.
  always @(negedge clk) begin
    if (out_calm_left == 0) begin
      out_calm      = ($urandom_range(0, 3) == 0);
      out_calm_left = $urandom_range(50, 300);
    end else begin
      out_calm_left--;
    end
    if (out_calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_ch.ready <= (stall_left == 0);
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int guard;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.list_start = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle after reset: dropped
    push_byte(8'hA5, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    // smallest run, offset of -128
    push_byte(8'h11, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h80, 1'b0, 1'b1);
    // widest run, all-ones length, largest positive offset
    push_byte(8'h44, 1'b0, 1'b1);
    repeat (4) push_byte(8'hFF, 1'b0, 1'b1);
    repeat (3) push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h7F, 1'b0, 1'b1);
    // sparse run of length zero
    push_byte(8'h01, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    // end of list, then a dropped header
    push_byte(END_HEADER, 1'b0, 1'b1);
    push_byte(8'h21, 1'b0, 1'b0);
    // restart mid-run, then illegal headers and an end of list
    push_byte(8'h22, 1'b1, 1'b1);
    push_byte(8'h01, 1'b0, 1'b1);
    push_byte(8'h10, 1'b1, 1'b1);
    push_byte(8'h51, 1'b1, 1'b1);
    push_byte(8'h05, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(END_HEADER, 1'b1, 1'b1);

    while (items_sent < NUM_ITEMS) send_list();
    in_ch.valid <= 1'b0;

    guard = 0;
    while (outstanding != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);

    if (outstanding != 0) $error("%0d decoded results never arrived", outstanding);
    $display("Sent %0d runlist bytes in %0d lists with random gaps and stalls",
             items_sent, lists_sent);
    $display("Checked %0d runs (%0d sparse), %0d list ends, %0d illegal headers",
             runs_seen, sparse_seen, ends_seen, bad_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
